### rtl/tpd_pkg.sv
`default_nettype none

package tpd_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int FREE_W     = $clog2(NODE_COUNT + 1);
   localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_PREFIX = 2'd2,
      OP_NONE   = 2'd3
   } tpd_op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINK,
      ST_MARK
   } tpd_state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] letter;
      logic       last_letter;
      logic       empty_word;
   } tpd_req_type;

   typedef struct packed {
      logic answer;
      logic pool_full;
   } tpd_rsp_type;

   // Access request from the walk control to the node store.
   typedef struct packed {
      logic               link_rd;
      logic               link_wr;
      logic [LINK_AW-1:0] link_addr;
      logic [NODE_W-1:0]  link_wdata;
      logic               mark_rd;
      logic               mark_wr;
      logic [NODE_W-1:0]  mark_addr;
   } tpd_mem_req_type;

endpackage

`default_nettype wire

### rtl/tpd_store.sv
`default_nettype none

module tpd_store (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tpd_pkg::tpd_mem_req_type   mem_req,
   output logic [tpd_pkg::NODE_W-1:0]      link_rdata,
   output logic                            mark_rdata,
   output logic                            clear_done
);
   import tpd_pkg::*;

   logic [NODE_W-1:0]  link_mem [LINK_DEPTH];
   logic               mark_mem [NODE_COUNT];

   logic [NODE_W-1:0]  link_rdata_ff;
   logic               mark_rdata_ff;
   logic [LINK_AW-1:0] clear_cnt_ff;
   logic [LINK_AW-1:0] clear_cnt_in;
   logic               clearing_ff;
   logic               clearing_in;
   logic               clear_last;

   assign clear_last = (int'(clear_cnt_ff) == LINK_DEPTH - 1);

   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      clearing_in  = clearing_ff;
      if (clearing_ff) begin
         clear_cnt_in = clear_cnt_ff + LINK_AW'(1);
         if (clear_last) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         clearing_ff  <= 1'b1;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         clearing_ff  <= clearing_in;
      end
   end

   // child link table: one port, sweep has priority
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         link_mem[clear_cnt_ff] <= '0;
      end else if (mem_req.link_wr) begin
         link_mem[mem_req.link_addr] <= mem_req.link_wdata;
      end
      if (mem_req.link_rd) begin
         link_rdata_ff <= link_mem[mem_req.link_addr];
      end
   end

   // word end marks
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         if (int'(clear_cnt_ff) < NODE_COUNT) begin
            mark_mem[clear_cnt_ff[NODE_W-1:0]] <= 1'b0;
         end
      end else if (mem_req.mark_wr) begin
         mark_mem[mem_req.mark_addr] <= 1'b1;
      end
      if (mem_req.mark_rd) begin
         mark_rdata_ff <= mark_mem[mem_req.mark_addr];
      end
   end

   assign link_rdata = link_rdata_ff;
   assign mark_rdata = mark_rdata_ff;
   assign clear_done = !clearing_ff;

endmodule

`default_nettype wire

### rtl/trie_prefix_dictionary_core.sv
`default_nettype none

// Trie dictionary of lower-case words. A word arrives one letter per item
// (req_item: operation, letter, last_letter, empty_word); the item that ends a
// word (last_letter or empty_word set) produces exactly one result on rsp_item,
// shown for one cycle with rsp_valid, unless its operation code is 3, which
// gives no result. The receiver cannot stall: results must be taken when
// rsp_valid is high. An item is taken when start is high and busy is low. A
// letter that walks the trie holds busy while the child link is read from the
// registered link memory read port (state LINK); an exact search whose walk
// reaches an existing node keeps it high for the word-end mark read (state
// MARK), as does a search for the empty word. Items that skip the walk (failed
// walk, letter past z, operation code 3, empty insert or prefix) leave busy low.
// After reset, busy stays high while the link and mark memories are swept to
// zero. A new node is allocated from a counter on insert; when the pool is
// exhausted the insert returns answer 0 and pool_full 1.
module trie_prefix_dictionary_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire tpd_pkg::tpd_req_type req_item,
   output logic                      rsp_valid,
   output tpd_pkg::tpd_rsp_type      rsp_item
);
   import tpd_pkg::*;

   tpd_state_type      state_ff, state_in;
   logic [NODE_W-1:0]  walk_node_ff, walk_node_in;
   logic               walk_failed_ff, walk_failed_in;
   logic               pool_hit_ff, pool_hit_in;
   logic [FREE_W-1:0]  next_free_ff, next_free_in;
   tpd_op_type         op_ff, op_in;
   logic               last_ff, last_in;
   logic [LINK_AW-1:0] slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tpd_rsp_type        rsp_item_ff, rsp_item_in;

   tpd_mem_req_type    mem_req;
   logic [NODE_W-1:0]  link_rdata;
   logic               mark_rdata;
   logic               clear_done;

   logic               accept;
   tpd_op_type         req_op;
   logic               letter_ok;
   logic               walk_go;
   logic [LINK_AW-1:0] slot;

   // outcome of one child-link lookup
   logic               pool_empty;
   logic               link_fail;
   logic               link_pool;
   logic               link_alloc;
   logic [NODE_W-1:0]  link_node;

   tpd_store u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .link_rdata (link_rdata),
      .mark_rdata (mark_rdata),
      .clear_done (clear_done)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign req_op    = tpd_op_type'(req_item.operation);
   assign letter_ok = (int'(req_item.letter) < ALPHABET_SIZE);
   assign walk_go   = (req_op != OP_NONE) && !req_item.empty_word
                      && !walk_failed_ff && letter_ok;
   assign slot      = LINK_AW'(walk_node_ff) * LINK_AW'(ALPHABET_SIZE)
                      + LINK_AW'(req_item.letter);

   assign pool_empty = (next_free_ff >= FREE_W'(NODE_COUNT));
   assign link_fail  = (link_rdata == '0) && ((op_ff != OP_INSERT) || pool_empty);
   assign link_pool  = (link_rdata == '0) && (op_ff == OP_INSERT) && pool_empty;
   assign link_alloc = (link_rdata == '0) && (op_ff == OP_INSERT) && !pool_empty;
   assign link_node  = link_alloc ? next_free_ff[NODE_W-1:0] : link_rdata;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (walk_go) begin
                  state_in = ST_LINK;
               end else if (req_item.empty_word && (req_op == OP_SEARCH)) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_LINK: begin
            if (last_ff && (op_ff == OP_SEARCH) && !link_fail) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // walk datapath, memory requests and results
   always_comb begin
      walk_node_in   = walk_node_ff;
      walk_failed_in = walk_failed_ff;
      pool_hit_in    = pool_hit_ff;
      next_free_in   = next_free_ff;
      op_in          = op_ff;
      last_in        = last_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = 1'b0;
      rsp_item_in    = '0;
      mem_req        = '0;
      mem_req.link_addr  = slot_ff;
      mem_req.link_wdata = next_free_ff[NODE_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_NONE) begin
                  if (req_item.last_letter || req_item.empty_word) begin
                     walk_node_in   = '0;
                     walk_failed_in = 1'b0;
                     pool_hit_in    = 1'b0;
                  end
               end else if (req_item.empty_word) begin
                  // word of no letters acts on the root
                  walk_node_in      = '0;
                  walk_failed_in    = 1'b0;
                  pool_hit_in       = 1'b0;
                  mem_req.mark_addr = '0;
                  case (req_op)
                     OP_INSERT: begin
                        mem_req.mark_wr    = 1'b1;
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.answer = 1'b1;
                     end
                     OP_SEARCH: begin
                        mem_req.mark_rd = 1'b1;
                     end
                     default: begin
                        rsp_valid_in       = 1'b1;
                        rsp_item_in.answer = 1'b1;
                     end
                  endcase
               end else if (walk_go) begin
                  mem_req.link_rd   = 1'b1;
                  mem_req.link_addr = slot;
                  slot_in           = slot;
                  op_in             = req_op;
                  last_in           = req_item.last_letter;
               end else begin
                  // walk already failed or letter out of range
                  walk_failed_in = 1'b1;
                  if (req_item.last_letter) begin
                     rsp_valid_in          = 1'b1;
                     rsp_item_in.pool_full = (req_op == OP_INSERT) && pool_hit_ff;
                     walk_node_in          = '0;
                     walk_failed_in        = 1'b0;
                     pool_hit_in           = 1'b0;
                  end
               end
            end
         end
         ST_LINK: begin
            if (link_alloc) begin
               mem_req.link_wr = 1'b1;
               next_free_in    = next_free_ff + FREE_W'(1);
            end
            if (!last_ff) begin
               walk_node_in   = link_fail ? walk_node_ff : link_node;
               walk_failed_in = link_fail;
               pool_hit_in    = link_pool;
            end else begin
               walk_node_in      = '0;
               walk_failed_in    = 1'b0;
               pool_hit_in       = 1'b0;
               mem_req.mark_addr = link_node;
               case (op_ff)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (!link_fail) begin
                        mem_req.mark_wr    = 1'b1;
                        rsp_item_in.answer = 1'b1;
                     end else begin
                        rsp_item_in.pool_full = link_pool;
                     end
                  end
                  OP_SEARCH: begin
                     if (link_fail) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_req.mark_rd = 1'b1;
                     end
                  end
                  OP_PREFIX: begin
                     rsp_valid_in       = 1'b1;
                     rsp_item_in.answer = !link_fail;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_MARK: begin
            rsp_valid_in       = 1'b1;
            rsp_item_in.answer = mark_rdata;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         walk_node_ff   <= '0;
         walk_failed_ff <= 1'b0;
         pool_hit_ff    <= 1'b0;
         next_free_ff   <= FREE_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walk_node_ff   <= walk_node_in;
         walk_failed_ff <= walk_failed_in;
         pool_hit_ff    <= pool_hit_in;
         next_free_ff   <= next_free_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      last_ff     <= last_in;
      slot_ff     <= slot_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff != '0) && (next_free_ff <= FREE_W'(NODE_COUNT)))
      else $error("free node counter out of range");

   a_walk_allocated: assert property (@(posedge clock) disable iff (reset)
      FREE_W'(walk_node_ff) < next_free_ff)
      else $error("walk points at an unallocated node");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      mem_req.link_wr |=> (next_free_ff == $past(next_free_ff) + FREE_W'(1)))
      else $error("node allocation did not advance the counter by one");

   a_link_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.link_rd && mem_req.link_wr))
      else $error("link memory read and write in the same cycle");

   a_mark_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |=> rsp_valid_ff)
      else $error("mark read gave no result");
`endif

endmodule

`default_nettype wire

### tb/sv/trie_prefix_dictionary_core_test.sv
`timescale 1ns / 1ps

module trie_prefix_dictionary_core_test;
   import tpd_pkg::*;

   // Longest stretch with neither an item nor a result taken. The sweep after
   // reset alone holds busy while every link memory entry is cleared.
   localparam int STALL_LIMIT = 120000;
   localparam int MAX_WORD    = 24;
   localparam int REPORT_MAX  = 30;

   localparam logic [4:0] LETTER_A = 5'd0;
   localparam logic [4:0] LETTER_Z = 5'd25;

   // One word as the stimulus sees it; size 0 goes out as an empty-word item.
   typedef struct packed {
      logic [4:0]               size;
      logic [MAX_WORD-1:0][4:0] text;
   } word_type;

   // Trie mirror: walks the same node table as the block and queues the
   // answer each finished word must produce.
   class trie_answer_model;
      logic [NODE_W-1:0] child_link [LINK_DEPTH];
      bit                word_mark  [NODE_COUNT];
      logic [NODE_W-1:0] walk_node;
      bit                walk_failed;
      bit                pool_hit;
      logic [FREE_W-1:0] next_free;
      tpd_rsp_type       pending_answers [$];
      int                error_count;

      function new();
         foreach (child_link[i]) child_link[i] = '0;
         foreach (word_mark[i]) word_mark[i] = 1'b0;
         next_free   = 1;
         error_count = 0;
         restart_walk();
      endfunction

      function void restart_walk();
         walk_node   = '0;
         walk_failed = 1'b0;
         pool_hit    = 1'b0;
      endfunction

      function void step_letter(tpd_op_type op, logic [4:0] letter);
         int                slot;
         logic [NODE_W-1:0] target;
         if (walk_failed) return;
         if (letter >= ALPHABET_SIZE) begin
            walk_failed = 1'b1;
            return;
         end
         slot   = int'(walk_node) * ALPHABET_SIZE + int'(letter);
         target = child_link[slot];
         if (target == '0) begin
            // only insert may grow the trie, and only while nodes remain
            if (op != OP_INSERT) begin
               walk_failed = 1'b1;
               return;
            end
            if (next_free >= NODE_COUNT) begin
               walk_failed = 1'b1;
               pool_hit    = 1'b1;
               return;
            end
            target = next_free[NODE_W-1:0];
            next_free++;
            child_link[slot] = target;
         end
         walk_node = target;
      endfunction

      function void end_word(tpd_op_type op);
         tpd_rsp_type res;
         res = '0;
         case (op)
            OP_INSERT: begin
               if (!walk_failed) begin
                  word_mark[walk_node] = 1'b1;
                  res.answer           = 1'b1;
               end else begin
                  res.pool_full = pool_hit;
               end
            end
            OP_SEARCH: res.answer = !walk_failed && word_mark[walk_node];
            default:   res.answer = !walk_failed;
         endcase
         pending_answers.push_back(res);
      endfunction

      function void note_item(tpd_req_type it);
         tpd_op_type op;
         op = tpd_op_type'(it.operation);
         if (op == OP_NONE) begin
            if (it.last_letter || it.empty_word) restart_walk();
         end else if (it.empty_word) begin
            // any partial walk is dropped; the word is the root itself
            restart_walk();
            end_word(op);
            restart_walk();
         end else begin
            step_letter(op, it.letter);
            if (it.last_letter) begin
               end_word(op);
               restart_walk();
            end
         end
      endfunction

      function void check_answer(tpd_rsp_type got);
         tpd_rsp_type want;
         if (pending_answers.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("%0t: result with no word pending: answer %0b pool_full %0b",
                        $time, got.answer, got.pool_full);
            return;
         end
         want = pending_answers.pop_front();
         if (got.answer !== want.answer || got.pool_full !== want.pool_full) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("%0t: expected answer %0b pool_full %0b, got answer %0b pool_full %0b",
                        $time, want.answer, want.pool_full, got.answer, got.pool_full);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   tpd_req_type req_item;
   logic        rsp_valid;
   tpd_rsp_type rsp_item;

   trie_answer_model answers;
   word_type         known_words [$];
   int               stall_count = 0;
   int               items_sent;
   int               idle_pct;
   bit               calm;

   trie_prefix_dictionary_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor: both handshakes are sampled at the edge, before the block's
   // registers update. The item is noted first so that a result in the same
   // cycle still meets the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) answers.note_item(req_item);
         if (rsp_valid) answers.check_answer(rsp_item);
         stall_count <= ((start && !busy) || rsp_valid) ? 0 : stall_count + 1;
      end
   end

   initial begin
      wait (stall_count >= STALL_LIMIT);
      $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Holds start until the item is taken, then maybe drops it and idles
   // with junk on the item bus.
   task automatic send_item(tpd_req_type it);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         start    <= 1'b0;
         req_item <= tpd_req_type'($urandom);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_letter(tpd_op_type op, logic [4:0] letter, logic last, logic empty);
      tpd_req_type it;
      it.operation   = op;
      it.letter      = letter;
      it.last_letter = last;
      it.empty_word  = empty;
      send_item(it);
   endtask

   // noise_pct: chance per letter of a stray operation code or a letter
   // anywhere in 0..31
   task automatic send_word(tpd_op_type op, word_type w, int noise_pct);
      tpd_req_type it;
      if (w.size == 0) begin
         send_letter(op, 5'($urandom), 1'($urandom), 1'b1);
         return;
      end
      for (int i = 0; i < w.size; i++) begin
         it.operation   = op;
         it.letter      = w.text[i];
         it.last_letter = (i == w.size - 1);
         it.empty_word  = 1'b0;
         if ($urandom_range(0, 99) < noise_pct) begin
            if ($urandom_range(0, 1)) it.operation = 2'($urandom_range(0, 3));
            else it.letter = 5'($urandom_range(0, 31));
         end
         send_item(it);
      end
   endtask

   function automatic word_type make_word(int min_len, int max_len, int top_letter);
      word_type w;
      w      = '0;
      w.size = 5'($urandom_range(min_len, max_len));
      for (int i = 0; i < MAX_WORD; i++) w.text[i] = 5'($urandom_range(0, top_letter));
      return w;
   endfunction

   // One random word. Apart from inserts, most traffic reuses stored words so
   // searches and prefix queries reach deep nodes; the rest is misses and noise.
   task automatic random_word(int insert_pct, bit long_words);
      word_type w;
      int       pick;
      pick     = $urandom_range(0, 99);
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      if (known_words.size() == 0 || pick < insert_pct) begin
         if (long_words) w = make_word(8, MAX_WORD, ALPHABET_SIZE - 1);
         else w = make_word(0, 6, $urandom_range(0, 1) ? 3 : ALPHABET_SIZE - 1);
         // keep empty words rare
         if (w.size == 0 && $urandom_range(0, 3) != 0) w.size = 1;
         known_words.push_back(w);
         send_word(OP_INSERT, w, 0);
      end else begin
         w = known_words[$urandom_range(0, known_words.size() - 1)];
         if (pick < insert_pct + (100 - insert_pct) * 35 / 100) begin
            send_word(OP_SEARCH, w, 0);
         end else if (pick < insert_pct + (100 - insert_pct) * 65 / 100) begin
            // proper prefix of a stored word, or the word itself when it has under two letters
            if (w.size > 1) w.size = 5'($urandom_range(1, w.size - 1));
            send_word($urandom_range(0, 1) ? OP_PREFIX : OP_SEARCH, w, 0);
         end else if (pick < insert_pct + (100 - insert_pct) * 80 / 100) begin
            send_word(tpd_op_type'($urandom_range(0, 2)), make_word(1, 6, 25), 0);
         end else if (pick < insert_pct + (100 - insert_pct) * 90 / 100) begin
            send_word(tpd_op_type'($urandom_range(0, 2)), w, 0);
         end else begin
            send_word(tpd_op_type'($urandom_range(0, 3)), w, 35);
         end
      end
   endtask

   initial begin
      int phase_end;
      answers     = new();
      items_sent  = 0;
      idle_pct    = 30;
      calm        = 1'b0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty words on a fresh trie: root unmarked, prefix query always true,
      // then an empty insert marks the root.
      send_letter(OP_SEARCH, LETTER_A, 1'b0, 1'b1);
      send_letter(OP_PREFIX, 5'd31, 1'b1, 1'b1);
      send_letter(OP_INSERT, 5'd17, 1'b0, 1'b1);
      send_letter(OP_SEARCH, LETTER_A, 1'b1, 1'b1);
      // one-letter words at both ends of the alphabet
      send_letter(OP_INSERT, LETTER_Z, 1'b1, 1'b0);
      send_letter(OP_SEARCH, LETTER_Z, 1'b1, 1'b0);
      send_letter(OP_PREFIX, LETTER_A, 1'b1, 1'b0);
      // "ab": "a" is then a prefix but not a word
      send_letter(OP_INSERT, LETTER_A, 1'b0, 1'b0);
      send_letter(OP_INSERT, 5'd1, 1'b1, 1'b0);
      send_letter(OP_SEARCH, LETTER_A, 1'b1, 1'b0);
      send_letter(OP_PREFIX, LETTER_A, 1'b1, 1'b0);
      // letters past z fail the walk
      send_letter(OP_SEARCH, 5'd31, 1'b1, 1'b0);
      send_letter(OP_INSERT, 5'd26, 1'b1, 1'b0);
      // code 3 gives no result but still ends the word
      send_letter(OP_NONE, LETTER_A, 1'b1, 1'b0);
      send_letter(OP_INSERT, 5'd2, 1'b0, 1'b0);
      send_letter(OP_NONE, 5'd3, 1'b0, 1'b1);
      // mixed codes on one walk: the ending item's code decides
      send_letter(OP_INSERT, 5'd16, 1'b0, 1'b0);
      send_letter(OP_SEARCH, 5'd17, 1'b1, 1'b0);
      // empty word drops the partial walk
      send_letter(OP_SEARCH, LETTER_A, 1'b0, 1'b0);
      send_letter(OP_PREFIX, LETTER_A, 1'b0, 1'b1);
      // once failed, later letters are skipped even if they would match
      send_letter(OP_SEARCH, 5'd24, 1'b0, 1'b0);
      send_letter(OP_SEARCH, LETTER_A, 1'b0, 1'b0);
      send_letter(OP_PREFIX, 5'd1, 1'b1, 1'b0);

      // short words, half of them over a narrow alphabet, share prefixes heavily
      while (items_sent < 450) random_word(35, 1'b0);
      // long fresh inserts until the node pool runs dry or 6000 items are sent
      while (answers.next_free < NODE_COUNT && items_sent < 6000) random_word(75, 1'b1);
      // full pool: inserts fail or hit existing words; last stretch back to back
      phase_end = items_sent + 350;
      while (items_sent < phase_end - 150) random_word(40, 1'b0);
      calm = 1'b1;
      while (items_sent < phase_end) random_word(40, 1'b0);
      start <= 1'b0;

      while (answers.pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (answers.error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/tpd_pkg.sv
rtl/tpd_store.sv
rtl/trie_prefix_dictionary_core.sv
tb/sv/trie_prefix_dictionary_core_test.sv
